>>> rtl/svf_pkg.sv
`timescale 1ns / 1ps

package svf_pkg;

  // configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_THREE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd4;

  // output select codes
  localparam logic [1:0] MODE_LOWPASS  = 2'd0;
  localparam logic [1:0] MODE_HIGHPASS = 2'd1;
  localparam logic [1:0] MODE_BANDPASS = 2'd2;
  localparam logic [1:0] MODE_NOTCH    = 2'd3;

endpackage

>>> rtl/svf_if.sv
`timescale 1ns / 1ps

interface svf_in_if #(parameter int SAMPLE_WIDTH = 24) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface svf_out_if #(parameter int SAMPLE_WIDTH = 24) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface svf_cfg_if ();
  import svf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

>>> rtl/state_variable_filter_top.sv
`timescale 1ns / 1ps

// channel   | direction | payload              | accepted when
// ----------+-----------+----------------------+----------------------
// in_chan   | in        | sample_in            | valid && ready
// out_chan  | out       | sample_out           | valid && ready
// cfg_chan  | in        | addr (index), data   | valid && ready
//
// one sample passes through the request cycle, five products through the one
// shared coefficient multiplier (a1*s1, a2*v3, a2*s1, a3*v3, k*v1), an
// integrator update and the output write; a stalled output adds its wait.
// rst_n is synchronous: it clears the sequencer, output valid, integrators
// and loads the register reset values; no clearing pass is needed.
// in_chan.ready is high only while the sequencer idles; cfg_chan is always ready.
module state_variable_filter_top #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 24,
  parameter int STATE_WIDTH    = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  svf_in_if.sink    in_chan,
  svf_out_if.source out_chan,
  svf_cfg_if.sink   cfg_chan
);
  import svf_pkg::*;

  // working widths
  localparam int SW   = SAMPLE_WIDTH;
  localparam int CF   = COEF_FRAC_BITS;
  localparam int STW  = STATE_WIDTH;
  localparam int MW   = ((SW > STW) ? SW : STW) + 1;  // v3 = x - s2
  localparam int AW   = MW + 6;                       // sums, highpass
  localparam int AC_W = CF + 1;                       // a1..a3
  localparam int CW   = CF + 2;                       // k, and multiplier coef port
  localparam int MAGW = MW + 1;                       // largest operand magnitude (v1)
  localparam int PW   = MAGW + CW + 1;                // product plus rounding half
  localparam int RW   = PW - CF;                      // rounded magnitude

  localparam logic [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (CF - 1);

  localparam logic signed [AW-1:0] ST_MAX = {{(AW-STW+1){1'b0}}, {(STW-1){1'b1}}};
  localparam logic signed [AW-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [AW-1:0] SW_MAX = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [AW-1:0] SW_MIN = ~SW_MAX;

  // sequencer codes
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL_A1S1 = 3'd1;
  localparam logic [2:0] S_MUL_A2V3 = 3'd2;
  localparam logic [2:0] S_MUL_A2S1 = 3'd3;
  localparam logic [2:0] S_MUL_A3V3 = 3'd4;
  localparam logic [2:0] S_MUL_KV1  = 3'd5;
  localparam logic [2:0] S_UPDATE   = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  // configuration registers
  logic [AC_W-1:0] coef_one_r, coef_two_r, coef_three_r;
  logic [CW-1:0]   damping_r;
  logic [1:0]      mode_r;

  // sequencer and datapath
  logic [2:0]            state_r, state_nxt;
  logic signed [STW-1:0] s1_r, s1_nxt, s2_r, s2_nxt;
  logic signed [SW-1:0]  x_r, x_nxt;
  logic signed [MW-1:0]  v3_r, v3_nxt;
  logic signed [AW-1:0]  v1_r, v1_nxt, v2_r, v2_nxt, kv_r, kv_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;
  logic                  neg_r, neg_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]  out_data_r, out_data_nxt;

  logic                  in_acc, out_acc, cfg_acc;
  logic [CW-1:0]         mul_coef;
  logic signed [AW-1:0]  mul_op, mul_abs;
  logic signed [AW-1:0]  x_ext, s1_ext, s2_ext, rnd, upd1, upd2, y;
  logic [RW-1:0]         rnd_mag;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_valid_r && out_chan.ready;
  assign cfg_acc = cfg_chan.valid && cfg_chan.ready;

  assign in_chan.ready       = (state_r == S_IDLE);
  assign cfg_chan.ready      = 1'b1;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_data_r;

  assign x_ext  = {{(AW-SW){x_r[SW-1]}}, x_r};
  assign s1_ext = {{(AW-STW){s1_r[STW-1]}}, s1_r};
  assign s2_ext = {{(AW-STW){s2_r[STW-1]}}, s2_r};

  // shared multiplier operand select
  always_comb begin
    mul_coef = '0;
    mul_op   = '0;
    unique case (state_r)
      S_MUL_A1S1: begin
        mul_coef = {1'b0, coef_one_r};
        mul_op   = s1_ext;
      end
      S_MUL_A2V3: begin
        mul_coef = {1'b0, coef_two_r};
        mul_op   = {{(AW-MW){v3_r[MW-1]}}, v3_r};
      end
      S_MUL_A2S1: begin
        mul_coef = {1'b0, coef_two_r};
        mul_op   = s1_ext;
      end
      S_MUL_A3V3: begin
        mul_coef = {1'b0, coef_three_r};
        mul_op   = {{(AW-MW){v3_r[MW-1]}}, v3_r};
      end
      S_MUL_KV1: begin
        mul_coef = damping_r;
        mul_op   = v1_r;
      end
      default: begin
        mul_coef = '0;
        mul_op   = '0;
      end
    endcase
  end

  // sign-magnitude product, rounded half away from zero and registered
  assign mul_abs  = mul_op[AW-1] ? -mul_op : mul_op;
  assign neg_nxt  = mul_op[AW-1];
  assign prod_nxt = {{(PW-CW){1'b0}}, mul_coef} * {{(PW-MAGW){1'b0}}, mul_abs[MAGW-1:0]}
                    + HALF;
  assign rnd_mag  = prod_r[PW-1:CF];
  assign rnd      = neg_r ? -{{(AW-RW){1'b0}}, rnd_mag} : {{(AW-RW){1'b0}}, rnd_mag};

  // trapezoidal integrator updates
  assign upd1 = (v1_r <<< 1) - s1_ext;
  assign upd2 = (v2_r <<< 1) - s2_ext;

  // mode select
  always_comb begin
    case (mode_r)
      MODE_LOWPASS:  y = v2_r;
      MODE_HIGHPASS: y = x_ext - kv_r - v2_r;
      MODE_BANDPASS: y = v1_r;
      default:       y = x_ext - kv_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    v3_nxt        = v3_r;
    v1_nxt        = v1_r;
    v2_nxt        = v2_r;
    kv_nxt        = kv_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    out_valid_nxt = out_valid_r && !out_acc;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_nxt     = in_chan.sample_in;
          v3_nxt    = {{(MW-SW){in_chan.sample_in[SW-1]}}, in_chan.sample_in}
                      - {{(MW-STW){s2_r[STW-1]}}, s2_r};
          v2_nxt    = s2_ext;
          state_nxt = S_MUL_A1S1;
        end
      end
      S_MUL_A1S1: state_nxt = S_MUL_A2V3;
      S_MUL_A2V3: begin
        v1_nxt    = rnd;                    // a1*s1
        state_nxt = S_MUL_A2S1;
      end
      S_MUL_A2S1: begin
        v1_nxt    = v1_r + rnd;             // + a2*v3
        state_nxt = S_MUL_A3V3;
      end
      S_MUL_A3V3: begin
        v2_nxt    = v2_r + rnd;             // s2 + a2*s1
        state_nxt = S_MUL_KV1;
      end
      S_MUL_KV1: begin
        v2_nxt    = v2_r + rnd;             // + a3*v3
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        kv_nxt    = rnd;                    // k*v1
        s1_nxt    = (upd1 > ST_MAX) ? ST_MAX[STW-1:0] :
                    (upd1 < ST_MIN) ? ST_MIN[STW-1:0] : upd1[STW-1:0];
        s2_nxt    = (upd2 > ST_MAX) ? ST_MAX[STW-1:0] :
                    (upd2 < ST_MIN) ? ST_MIN[STW-1:0] : upd2[STW-1:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait here while an earlier result is still unclaimed
        if (!out_valid_r || out_chan.ready) begin
          out_data_nxt  = (y > SW_MAX) ? SW_MAX[SW-1:0] :
                          (y < SW_MIN) ? SW_MIN[SW-1:0] : y[SW-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    neg_r      <= neg_nxt;
    x_r        <= x_nxt;
    v3_r       <= v3_nxt;
    v1_r       <= v1_nxt;
    v2_r       <= v2_nxt;
    kv_r       <= kv_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      s1_r        <= '0;
      s2_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      s1_r        <= s1_nxt;
      s2_r        <= s2_nxt;
    end
  end

  // register file writes, out-of-range indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_one_r   <= {1'b1, {CF{1'b0}}};
      coef_two_r   <= '0;
      coef_three_r <= '0;
      damping_r    <= {2'b10, {CF{1'b0}}};
      mode_r       <= MODE_LOWPASS;
    end else if (cfg_acc) begin
      unique case (cfg_chan.addr)
        REG_COEF_ONE:    coef_one_r   <= cfg_chan.data[AC_W-1:0];
        REG_COEF_TWO:    coef_two_r   <= cfg_chan.data[AC_W-1:0];
        REG_COEF_THREE:  coef_three_r <= cfg_chan.data[AC_W-1:0];
        REG_DAMPING:     damping_r    <= cfg_chan.data[CW-1:0];
        REG_FILTER_MODE: mode_r       <= cfg_chan.data[1:0];
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result only appears from the output step
  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("output valid rose outside the output step");

  // integrators move only in the update step
  a_integ_update: assert property (@(posedge clk) disable iff (!rst_n)
    (!$stable(s1_r) || !$stable(s2_r)) |-> ($past(state_r) == S_UPDATE || !$past(rst_n)))
    else $error("integrator changed outside the update step");

  // an accepted request starts the multiply sequence
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_MUL_A1S1)
    else $error("accepted request did not start the sequence");
`endif

endmodule

>>> tb/tb_state_variable_filter_top.sv
`timescale 1ns / 1ps

module tb_state_variable_filter_top;
  import svf_pkg::*;

  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 24;
  localparam int STATE_WIDTH    = 32;

  // cycles without any accepted transfer before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // random phases and samples per phase
  localparam int PHASE_COUNT = 12;
  localparam int PHASE_ITEMS = 152;
  // settle time after the last result
  localparam int DRAIN_CYCLES = 16;

  localparam real UNITY = 2.0 ** COEF_FRAC_BITS;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic clk;
  logic rst_n;

  svf_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) in_if ();
  svf_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) out_if ();
  svf_cfg_if cfg_if ();

  state_variable_filter_top #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .STATE_WIDTH   (STATE_WIDTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // samples waiting to be sent, filtered samples waiting to come back
  logic signed [SAMPLE_WIDTH-1:0] pending_samples[$];
  logic signed [SAMPLE_WIDTH-1:0] expected_outputs[$];

  // idle rates in percent, changed only while nothing is in flight
  int unsigned sender_gap_pct;
  int unsigned sink_stall_pct;
  int          error_count;
  int          idle_cycles;

  // shadow of the filter registers
  logic [COEF_FRAC_BITS:0]   coef_a1;
  logic [COEF_FRAC_BITS:0]   coef_a2;
  logic [COEF_FRAC_BITS:0]   coef_a3;
  logic [COEF_FRAC_BITS+1:0] coef_k;
  logic [1:0]                out_mode;

  // shadow of the two integrators, kept wide and signed
  longint integ_one;
  longint integ_two;

  // round(c * v / 2^frac), ties away from zero, c unsigned
  function automatic longint coef_product(logic [COEF_FRAC_BITS+1:0] c, longint v);
    logic [127:0] mag;
    logic [127:0] prod;
    mag  = (v < 0) ? 128'(-v) : 128'(v);
    prod = (mag * 128'(c) + (128'd1 << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
    return (v < 0) ? -$signed(prod[63:0]) : $signed(prod[63:0]);
  endfunction

  function automatic longint clamp_signed(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one filter step: returns the selected output, advances the integrators
  function automatic logic signed [SAMPLE_WIDTH-1:0] filter_sample(
    logic signed [SAMPLE_WIDTH-1:0] x_in
  );
    longint x, s1, s2, v1, v2, v3, kv1, y;
    x   = longint'(x_in);
    s1  = integ_one;
    s2  = integ_two;
    v3  = x - s2;
    v1  = coef_product({1'b0, coef_a1}, s1) + coef_product({1'b0, coef_a2}, v3);
    v2  = s2 + coef_product({1'b0, coef_a2}, s1) + coef_product({1'b0, coef_a3}, v3);
    kv1 = coef_product(coef_k, v1);
    integ_one = clamp_signed(2 * v1 - s1, STATE_WIDTH);
    integ_two = clamp_signed(2 * v2 - s2, STATE_WIDTH);
    y = 0;
    case (out_mode)
      MODE_LOWPASS:  y = v2;
      MODE_HIGHPASS: y = x - kv1 - v2;
      MODE_BANDPASS: y = v1;
      MODE_NOTCH:    y = x - kv1;
    endcase
    y = clamp_signed(y, SAMPLE_WIDTH);
    return y[SAMPLE_WIDTH-1:0];
  endfunction

  // register write as the block sees it: upper bits dropped, unknown index ignored
  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_COEF_ONE:    coef_a1  = val[COEF_FRAC_BITS:0];
      REG_COEF_TWO:    coef_a2  = val[COEF_FRAC_BITS:0];
      REG_COEF_THREE:  coef_a3  = val[COEF_FRAC_BITS:0];
      REG_DAMPING:     coef_k   = val[COEF_FRAC_BITS+1:0];
      REG_FILTER_MODE: out_mode = val[1:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // one register write request, held until taken
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_register(idx, val);
    cfg_if.valid <= 1'b0;
  endtask

  // coefficients as software would derive them from g = tan(pi fc / fs) and k
  task automatic write_tuned(input real g, input real k);
    real a1;
    a1 = 1.0 / (1.0 + g * (g + k));
    write_register(REG_COEF_ONE,   CFG_DATA_W'($rtoi(a1 * UNITY + 0.5)));
    write_register(REG_COEF_TWO,   CFG_DATA_W'($rtoi(g * a1 * UNITY + 0.5)));
    write_register(REG_COEF_THREE, CFG_DATA_W'($rtoi(g * g * a1 * UNITY + 0.5)));
    write_register(REG_DAMPING,    CFG_DATA_W'($rtoi(k * UNITY + 0.5)));
  endtask

  // mode write with junk in the bits above the field
  task automatic write_mode(input logic [1:0] m);
    write_register(REG_FILTER_MODE, ($urandom & ~CFG_DATA_W'(3)) | CFG_DATA_W'(m));
  endtask

  // a write to an index past the register list, must change nothing
  task automatic write_unused();
    write_register(CFG_IDX_W'(REG_FILTER_MODE + $urandom_range(1, 3)), $urandom);
  endtask

  // block until every sample is sent and every output is back
  task automatic wait_drained();
    @(negedge clk);
    while (pending_samples.size() != 0 || expected_outputs.size() != 0) @(negedge clk);
  endtask

  // driver: present the head of the queue, hold it until taken, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_outputs.push_back(filter_sample(in_if.sample_in));
        void'(pending_samples.pop_front());
      end
      if (in_if.valid && !in_if.ready) begin
        // request still waiting, leave it alone
      end else if (pending_samples.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
        in_if.valid     <= 1'b1;
        in_if.sample_in <= pending_samples[0];
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor: compare each output request with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_outputs.size() == 0) begin
          report_mismatch($sformatf("sample_out %0d with no sample pending",
                                    out_if.sample_out));
        end else begin
          if (out_if.sample_out !== expected_outputs[0])
            report_mismatch($sformatf("sample_out got %0d want %0d",
                                      out_if.sample_out, expected_outputs[0]));
          void'(expected_outputs.pop_front());
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // watchdog: a long stretch with no accepted transfer on any channel means a hang
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("state_variable_filter_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    logic [1:0] mode_list[4] = '{MODE_LOWPASS, MODE_HIGHPASS, MODE_BANDPASS, MODE_NOTCH};
    logic signed [SAMPLE_WIDTH-1:0] held;
    logic signed [SAMPLE_WIDTH-1:0] smp;
    int unsigned style;
    int          run_left;
    int          p;
    int          n;

    // known levels on every input from time zero
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.addr     = '0;
    cfg_if.data     = '0;
    error_count     = 0;
    sender_gap_pct  = 19;
    sink_stall_pct  = 49;

    // power-on register values and cleared integrators
    coef_a1   = (COEF_FRAC_BITS + 1)'(1) << COEF_FRAC_BITS;
    coef_a2   = '0;
    coef_a3   = '0;
    coef_k    = (COEF_FRAC_BITS + 2)'(2) << COEF_FRAC_BITS;
    out_mode  = MODE_LOWPASS;
    integ_one = 0;
    integ_two = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset coefficients first, then a resonant tuning through every mode
    @(negedge clk);
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back(SAMPLE_WIDTH'(12345));
    wait_drained();
    write_tuned(0.8, 0.3);
    write_unused();
    foreach (mode_list[m]) begin
      write_mode(mode_list[m]);
      @(negedge clk);
      // full-scale steps both ways, then back toward zero
      pending_samples.push_back(SAMPLE_MAX);
      pending_samples.push_back(SAMPLE_MAX);
      pending_samples.push_back(SAMPLE_MIN);
      pending_samples.push_back('0);
      pending_samples.push_back('1);
      wait_drained();
    end

    // random phases: each idle setting sees every kind of tuning
    for (p = 0; p < PHASE_COUNT; p++) begin
      if (p == PHASE_COUNT / 3) begin
        sender_gap_pct = 49;
        sink_stall_pct = 19;
      end else if (p == 2 * PHASE_COUNT / 3) begin
        sender_gap_pct = 0;
        sink_stall_pct = 0;
      end

      case (p % 4)
        0: begin
          // stable tuning over the usable cutoff and resonance span
          write_tuned($urandom_range(5, 3000) / 1000.0, $urandom_range(100, 2000) / 1000.0);
        end
        1: begin
          // in-range raw values with junk above each field
          write_register(REG_COEF_ONE,   ($urandom & ~32'h01FF_FFFF) | $urandom_range(0, 1 << 24));
          write_register(REG_COEF_TWO,   ($urandom & ~32'h01FF_FFFF) | $urandom_range(0, 1 << 24));
          write_register(REG_COEF_THREE, ($urandom & ~32'h01FF_FFFF) | $urandom_range(0, 1 << 24));
          write_register(REG_DAMPING,    ($urandom & ~32'h03FF_FFFF) |
                                         $urandom_range(1677722, 1 << 25));
        end
        2: begin
          if (p < PHASE_COUNT / 2) begin
            // coefficients near 2.0 and no damping: runs away into saturation
            write_register(REG_COEF_ONE,   32'hFFFF_FFFF);
            write_register(REG_COEF_TWO,   32'hFFFF_FFFF);
            write_register(REG_COEF_THREE, 32'hFFFF_FFFF);
            write_register(REG_DAMPING,    '0);
          end else begin
            // all-zero coefficients and the largest damping the field holds
            write_register(REG_COEF_ONE,   '0);
            write_register(REG_COEF_TWO,   '0);
            write_register(REG_COEF_THREE, '0);
            write_register(REG_DAMPING,    32'hFFFF_FFFF);
          end
        end
        default: begin
          // top of the nominal ranges, damping at one end or the other
          write_register(REG_COEF_ONE,   CFG_DATA_W'(1 << 24));
          write_register(REG_COEF_TWO,   CFG_DATA_W'(1 << 24));
          write_register(REG_COEF_THREE, CFG_DATA_W'(1 << 24));
          write_register(REG_DAMPING,    (p < PHASE_COUNT / 2) ? CFG_DATA_W'(1 << 25)
                                                               : CFG_DATA_W'(1677722));
        end
      endcase
      write_mode(mode_list[(p + p / 4) % 4]);
      write_unused();

      // bursts of one signal shape at a time
      @(negedge clk);
      run_left = 0;
      style    = 0;
      held     = '0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          style    = $urandom_range(0, 3);
          run_left = $urandom_range(1, 24);
          held     = SAMPLE_WIDTH'($urandom);
        end
        case (style)
          0:       smp = SAMPLE_WIDTH'($urandom);
          1:       smp = SAMPLE_WIDTH'(int'($urandom_range(0, 4095)) - 2048);
          2:       smp = held;
          default: smp = n[0] ? SAMPLE_MAX : SAMPLE_MIN;
        endcase
        pending_samples.push_back(smp);
        run_left--;
      end
      wait_drained();
    end

    // let any stray output show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_outputs.size() != 0)
      report_mismatch($sformatf("%0d outputs never arrived", expected_outputs.size()));
    if (error_count == 0) begin
      $display("state_variable_filter_top regression: pass");
    end else begin
      $display("state_variable_filter_top regression: fail");
    end
    $finish;
  end

endmodule
